>>> hw/rtl/tis_pkg.sv
// Shared types and constants for the triplet index sampler.
// No dependencies; imported by tis_mod, triplet_index_sampler and the testbench.
`timescale 1ns / 1ps
package tis_pkg;
   localparam int MAX_IMAGES  = 65536;
   localparam int MAX_CLASSES = 1024;

   localparam int KIND_W = 2;
   localparam int IDX_W  = 16;
   localparam int VAL_W  = 17;
   localparam int CNT_W  = 17;
   localparam int CLS_W  = 10;
   localparam int CS_AW  = 11;
   localparam int RAND_W = 32;
   localparam int ERR_W  = 2;
   localparam int SGN_W  = 19;

   // modulo unit: 32-bit dividend, 17-bit divisor, one quotient bit per stage
   localparam int DVD_W      = RAND_W;
   localparam int DIV_W      = 17;
   localparam int MOD_STAGES = DVD_W;

   localparam int CS_DEPTH  = MAX_CLASSES + 1;
   localparam int COI_DEPTH = MAX_IMAGES;

   localparam logic [KIND_W-1:0] KIND_LOAD_CLASS = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LOAD_START = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SAMPLE     = 2'd2;
   localparam logic [KIND_W-1:0] KIND_NOP        = 2'd3;

   localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
   localparam logic [ERR_W-1:0] ERR_SMALL     = 2'd1;
   localparam logic [ERR_W-1:0] ERR_NO_OTHER  = 2'd2;

   localparam logic [2:0] ADDR_IMAGE_COUNT = 3'd0;

   typedef struct packed {
      logic              valid;
      logic [KIND_W-1:0] kind;
      logic [IDX_W-1:0]  tidx;
      logic [VAL_W-1:0]  tval;
      logic [RAND_W-1:0] rp;
      logic [RAND_W-1:0] rn;
   } side_type;

   typedef struct packed {
      logic              valid;
      logic              sample;
      logic [IDX_W-1:0]  anchor;
      logic [VAL_W-1:0]  start;
      logic [SGN_W-1:0]  csize;
      logic [ERR_W-1:0]  err;
   } mid_type;
endpackage

>>> hw/rtl/tis_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module tis_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

>>> hw/rtl/tis_mod.sv
// Pipelined restoring remainder: 32-bit dividend mod 17-bit divisor,
// one bit per stage, advancing on enable. Depends on tis_pkg.
`timescale 1ns / 1ps
module tis_mod (
   input  logic                       clock,
   input  logic                       enable,
   input  logic [tis_pkg::DVD_W-1:0]  dividend,
   input  logic [tis_pkg::DIV_W-1:0]  divisor,
   output logic [tis_pkg::DIV_W-1:0]  remainder
);
   import tis_pkg::*;

   logic [DIV_W-1:0] rem_ff  [MOD_STAGES];
   logic [DVD_W-1:0] dvd_ff  [MOD_STAGES-1];
   logic [DIV_W-1:0] div_ff  [MOD_STAGES-1];
   logic [DIV_W-1:0] rem_in  [MOD_STAGES];
   logic [DIV_W-1:0] r_prev  [MOD_STAGES];
   logic [DVD_W-1:0] v_prev  [MOD_STAGES];
   logic [DIV_W-1:0] d_prev  [MOD_STAGES];
   logic [DIV_W:0]   trial   [MOD_STAGES];

   always_comb begin
      for (int i = 0; i < MOD_STAGES; i++) begin
         if (i == 0) begin
            r_prev[i] = '0;
            v_prev[i] = dividend;
            d_prev[i] = divisor;
         end else begin
            r_prev[i] = rem_ff[i-1];
            v_prev[i] = dvd_ff[i-1];
            d_prev[i] = div_ff[i-1];
         end
         trial[i] = {r_prev[i], v_prev[i][DVD_W-1]};
         // partial remainder stays below the divisor, so one subtract suffices
         if (trial[i] >= {1'b0, d_prev[i]}) begin
            rem_in[i] = DIV_W'(trial[i] - {1'b0, d_prev[i]});
         end else begin
            rem_in[i] = trial[i][DIV_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int i = 0; i < MOD_STAGES; i++) begin
            rem_ff[i] <= rem_in[i];
         end
         for (int i = 0; i < MOD_STAGES - 1; i++) begin
            dvd_ff[i] <= {v_prev[i][DVD_W-2:0], 1'b0};
            div_ff[i] <= d_prev[i];
         end
      end
   end

   assign remainder = rem_ff[MOD_STAGES-1];
endmodule

>>> hw/rtl/triplet_index_sampler.sv
// Triplet index sampler: 68 register stages, which every item passes through from
// its input transfer to the result register; throughput one item per cycle while no
// result is stalled. The stages are the 32-stage anchor modulo, three table/divisor
// stages, the two parallel 32-stage modulo units and the result register. A stalled
// result freezes the whole pipeline. Synchronous reset clears the valid bits and sets
// image_count to 1; table contents are undefined. Depends on tis_pkg, tis_mod, tis_ram.
`timescale 1ns / 1ps
module triplet_index_sampler (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [tis_pkg::KIND_W-1:0]  req_kind,
   input  logic [tis_pkg::IDX_W-1:0]   req_table_index,
   input  logic [tis_pkg::VAL_W-1:0]   req_table_value,
   input  logic [tis_pkg::RAND_W-1:0]  req_rand_anchor,
   input  logic [tis_pkg::RAND_W-1:0]  req_rand_positive,
   input  logic [tis_pkg::RAND_W-1:0]  req_rand_negative,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [tis_pkg::IDX_W-1:0]   rsp_anchor_index,
   output logic [tis_pkg::IDX_W-1:0]   rsp_positive_index,
   output logic [tis_pkg::IDX_W-1:0]   rsp_negative_index,
   output logic [tis_pkg::ERR_W-1:0]   rsp_sample_error,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [2:0]                  paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);
   import tis_pkg::*;

   logic             en;
   logic [CNT_W-1:0] image_count_ff;
   logic [CNT_W-1:0] n_eff;

   // ---- register port
   assign pready = 1'b1;
   assign prdata = (paddr == ADDR_IMAGE_COUNT) ? {15'd0, image_count_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_count_ff <= CNT_W'(1);
      end else if (psel && penable && pwrite && paddr == ADDR_IMAGE_COUNT) begin
         image_count_ff <= pwdata[CNT_W-1:0];
      end
   end

   always_comb begin
      if (image_count_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (image_count_ff > CNT_W'(MAX_IMAGES)) begin
         n_eff = CNT_W'(MAX_IMAGES);
      end else begin
         n_eff = image_count_ff;
      end
   end

   // whole pipeline moves unless a result is held
   logic rsp_valid_ff;
   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   // ---- anchor modulo with sideband
   side_type         side_ff [MOD_STAGES];
   side_type         side_in;
   logic [DIV_W-1:0] anchor_rem;

   always_comb begin
      side_in.valid = req_valid;
      side_in.kind  = req_kind;
      side_in.tidx  = req_table_index;
      side_in.tval  = req_table_value;
      side_in.rp    = req_rand_positive;
      side_in.rn    = req_rand_negative;
   end

   tis_mod u_mod_anchor (
      .clock     (clock),
      .enable    (en),
      .dividend  (req_rand_anchor),
      .divisor   (n_eff),
      .remainder (anchor_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MOD_STAGES; i++) begin
            side_ff[i].valid <= 1'b0;
         end
      end else if (en) begin
         side_ff[0].valid <= side_in.valid;
         for (int i = 1; i < MOD_STAGES; i++) begin
            side_ff[i].valid <= side_ff[i-1].valid;
         end
      end
      if (en) begin
         side_ff[0].kind <= side_in.kind;
         side_ff[0].tidx <= side_in.tidx;
         side_ff[0].tval <= side_in.tval;
         side_ff[0].rp   <= side_in.rp;
         side_ff[0].rn   <= side_in.rn;
         for (int i = 1; i < MOD_STAGES; i++) begin
            side_ff[i].kind <= side_ff[i-1].kind;
            side_ff[i].tidx <= side_ff[i-1].tidx;
            side_ff[i].tval <= side_ff[i-1].tval;
            side_ff[i].rp   <= side_ff[i-1].rp;
            side_ff[i].rn   <= side_ff[i-1].rn;
         end
      end
   end

   // ---- class lookup; class loads are written in order at this stage
   side_type         s1;
   logic [IDX_W-1:0] s1_anchor;
   logic             coi_we;
   logic [CLS_W-1:0] coi_rdata;

   assign s1        = side_ff[MOD_STAGES-1];
   assign s1_anchor = anchor_rem[IDX_W-1:0];
   assign coi_we    = en && s1.valid && s1.kind == KIND_LOAD_CLASS
                      && s1.tval < VAL_W'(MAX_CLASSES);

   tis_ram #(.WIDTH(CLS_W), .DEPTH(COI_DEPTH)) u_class_of_image (
      .clock (clock),
      .we    (coi_we),
      .waddr (s1.tidx),
      .wdata (s1.tval[CLS_W-1:0]),
      .re    (en),
      .raddr (s1_anchor),
      .rdata (coi_rdata)
   );

   side_type         s2_ff;
   logic [IDX_W-1:0] s2_anchor_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff.valid <= 1'b0;
      end else if (en) begin
         s2_ff.valid <= s1.valid;
      end
      if (en) begin
         s2_ff.kind   <= s1.kind;
         s2_ff.tidx   <= s1.tidx;
         s2_ff.tval   <= s1.tval;
         s2_ff.rp     <= s1.rp;
         s2_ff.rn     <= s1.rn;
         s2_ff_anchor_copy: begin
            s2_anchor_ff <= s1_anchor;
         end
      end
   end

   // ---- class start and end, two copies of the start table
   logic             cs_we;
   logic [CS_AW-1:0] cs_lo_addr;
   logic [CS_AW-1:0] cs_hi_addr;
   logic [VAL_W-1:0] cs_lo_rdata;
   logic [VAL_W-1:0] cs_hi_rdata;

   assign cs_we      = en && s2_ff.valid && s2_ff.kind == KIND_LOAD_START
                       && s2_ff.tidx <= IDX_W'(MAX_CLASSES);
   assign cs_lo_addr = {1'b0, coi_rdata};
   assign cs_hi_addr = {1'b0, coi_rdata} + CS_AW'(1);

   tis_ram #(.WIDTH(VAL_W), .DEPTH(CS_DEPTH)) u_class_start_lo (
      .clock (clock),
      .we    (cs_we),
      .waddr (s2_ff.tidx[CS_AW-1:0]),
      .wdata (s2_ff.tval),
      .re    (en),
      .raddr (cs_lo_addr),
      .rdata (cs_lo_rdata)
   );

   tis_ram #(.WIDTH(VAL_W), .DEPTH(CS_DEPTH)) u_class_start_hi (
      .clock (clock),
      .we    (cs_we),
      .waddr (s2_ff.tidx[CS_AW-1:0]),
      .wdata (s2_ff.tval),
      .re    (en),
      .raddr (cs_hi_addr),
      .rdata (cs_hi_rdata)
   );

   logic              s3_valid_ff;
   logic              s3_sample_ff;
   logic [RAND_W-1:0] s3_rp_ff;
   logic [RAND_W-1:0] s3_rn_ff;
   logic [IDX_W-1:0]  s3_anchor_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= s2_ff.valid;
      end
      if (en) begin
         s3_sample_ff <= (s2_ff.kind == KIND_SAMPLE);
         s3_rp_ff     <= s2_ff.rp;
         s3_rn_ff     <= s2_ff.rn;
         s3_anchor_ff <= s2_anchor_ff;
      end
   end

   // ---- class size and divisors
   logic signed [SGN_W-1:0] csize;
   logic signed [SGN_W-1:0] div_pos;
   logic signed [SGN_W-1:0] div_neg;
   logic [ERR_W-1:0]        err3;

   always_comb begin
      csize   = $signed({2'b00, cs_hi_rdata}) - $signed({2'b00, cs_lo_rdata});
      div_pos = csize - SGN_W'(1);
      div_neg = $signed({2'b00, n_eff}) - csize;
      if (div_pos <= 0) begin
         err3 = ERR_SMALL;
      end else if (div_neg <= 0) begin
         err3 = ERR_NO_OTHER;
      end else begin
         err3 = ERR_NONE;
      end
   end

   mid_type           s4_ff;
   logic [RAND_W-1:0] s4_rp_ff;
   logic [RAND_W-1:0] s4_rn_ff;
   logic [DIV_W-1:0]  s4_dpos_ff;
   logic [DIV_W-1:0]  s4_dneg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_ff.valid <= 1'b0;
      end else if (en) begin
         s4_ff.valid <= s3_valid_ff;
      end
      if (en) begin
         s4_ff.sample <= s3_sample_ff;
         s4_ff.anchor <= s3_anchor_ff;
         s4_ff.start  <= cs_lo_rdata;
         s4_ff.csize  <= csize;
         s4_ff.err    <= err3;
         s4_rp_ff     <= s3_rp_ff;
         s4_rn_ff     <= s3_rn_ff;
         s4_dpos_ff   <= div_pos[DIV_W-1:0];
         s4_dneg_ff   <= div_neg[DIV_W-1:0];
      end
   end

   // ---- positive and negative modulo
   logic [DIV_W-1:0] pos_rem;
   logic [DIV_W-1:0] neg_rem;
   mid_type          mid_ff [MOD_STAGES];

   tis_mod u_mod_pos (
      .clock     (clock),
      .enable    (en),
      .dividend  (s4_rp_ff),
      .divisor   (s4_dpos_ff),
      .remainder (pos_rem)
   );

   tis_mod u_mod_neg (
      .clock     (clock),
      .enable    (en),
      .dividend  (s4_rn_ff),
      .divisor   (s4_dneg_ff),
      .remainder (neg_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MOD_STAGES; i++) begin
            mid_ff[i].valid <= 1'b0;
         end
      end else if (en) begin
         mid_ff[0].valid <= s4_ff.valid;
         for (int i = 1; i < MOD_STAGES; i++) begin
            mid_ff[i].valid <= mid_ff[i-1].valid;
         end
      end
      if (en) begin
         mid_ff[0].sample <= s4_ff.sample;
         mid_ff[0].anchor <= s4_ff.anchor;
         mid_ff[0].start  <= s4_ff.start;
         mid_ff[0].csize  <= s4_ff.csize;
         mid_ff[0].err    <= s4_ff.err;
         for (int i = 1; i < MOD_STAGES; i++) begin
            mid_ff[i].sample <= mid_ff[i-1].sample;
            mid_ff[i].anchor <= mid_ff[i-1].anchor;
            mid_ff[i].start  <= mid_ff[i-1].start;
            mid_ff[i].csize  <= mid_ff[i-1].csize;
            mid_ff[i].err    <= mid_ff[i-1].err;
         end
      end
   end

   // ---- offset correction
   mid_type          m;
   logic [VAL_W:0]   pos_sum;
   logic [SGN_W-1:0] neg_sum;
   logic [IDX_W-1:0] pos_out;
   logic [IDX_W-1:0] neg_out;

   assign m = mid_ff[MOD_STAGES-1];

   always_comb begin
      pos_sum = {1'b0, pos_rem} + {1'b0, m.start};
      if (pos_sum >= {2'b00, m.anchor}) begin
         pos_sum = pos_sum + (VAL_W+1)'(1);   // skip the anchor itself
      end
      neg_sum = {2'b00, neg_rem};
      if (neg_rem >= m.start) begin
         neg_sum = neg_sum + m.csize;          // jump over the anchor's class
      end
      if (m.err == ERR_SMALL) begin
         pos_out = '0;
         neg_out = '0;
      end else if (m.err == ERR_NO_OTHER) begin
         pos_out = pos_sum[IDX_W-1:0];
         neg_out = '0;
      end else begin
         pos_out = pos_sum[IDX_W-1:0];
         neg_out = neg_sum[IDX_W-1:0];
      end
   end

   // ---- result register
   logic [IDX_W-1:0] rsp_anchor_ff;
   logic [IDX_W-1:0] rsp_pos_ff;
   logic [IDX_W-1:0] rsp_neg_ff;
   logic [ERR_W-1:0] rsp_err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= m.valid && m.sample;
      end
      if (en) begin
         rsp_anchor_ff <= m.anchor;
         rsp_pos_ff    <= pos_out;
         rsp_neg_ff    <= neg_out;
         rsp_err_ff    <= m.err;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_anchor_index   = rsp_anchor_ff;
   assign rsp_positive_index = rsp_pos_ff;
   assign rsp_negative_index = rsp_neg_ff;
   assign rsp_sample_error   = rsp_err_ff;
endmodule

>>> dv/tb.sv
// Testbench for triplet_index_sampler: directed table plus random phases,
// every result checked against an in-bench triplet predictor or a typed expectation.
// Depends on tis_pkg and the triplet_index_sampler RTL.
`timescale 1ns / 1ps
module tb;
   import tis_pkg::*;

   localparam int DRAIN_CYCLES = 80;
   localparam int IDLE_LIMIT   = 3000;
   localparam int HOLD_CYCLES  = 300;

   typedef struct packed {
      logic [IDX_W-1:0] anchor;
      logic [IDX_W-1:0] positive;
      logic [IDX_W-1:0] negative;
      logic [ERR_W-1:0] err;
   } triplet_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [IDX_W-1:0]  tidx;
      logic [VAL_W-1:0]  tval;
      logic [RAND_W-1:0] ra;
      logic [RAND_W-1:0] rp;
      logic [RAND_W-1:0] rn;
      logic              typed;
      triplet_type       want;
   } stim_row_type;

   logic                clock = 0;
   logic                reset;
   logic                req_valid, req_stall;
   logic [KIND_W-1:0]   req_kind;
   logic [IDX_W-1:0]    req_table_index;
   logic [VAL_W-1:0]    req_table_value;
   logic [RAND_W-1:0]   req_rand_anchor, req_rand_positive, req_rand_negative;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [IDX_W-1:0]    rsp_anchor_index, rsp_positive_index, rsp_negative_index;
   logic [ERR_W-1:0]    rsp_sample_error;
   logic                psel, penable, pwrite, pready;
   logic [2:0]          paddr;
   logic [31:0]         pwdata, prdata;

   // typed expectation travels with the item on the request side
   logic                cur_typed;
   triplet_type         cur_want;

   // predictor state
   logic [CLS_W-1:0]    class_of_img [COI_DEPTH];
   logic [VAL_W-1:0]    class_begin  [CS_DEPTH];
   bit                  img_loaded   [COI_DEPTH];
   bit                  begin_loaded [CS_DEPTH];
   logic [CNT_W-1:0]    img_total;

   triplet_type         triplet_q[$];
   int                  errors = 0;
   int                  idle_cycles = 0;
   bit                  hold_off = 0;
   int                  stall_mode = 0;
   int                  num_classes, layout_len;

   always #1 clock = ~clock;

   triplet_index_sampler i_dut (.*);

   task automatic report(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
   endtask

   function automatic bit sample_triplet(input logic [KIND_W-1:0] kind,
         input logic [IDX_W-1:0] tidx, input logic [VAL_W-1:0] tval,
         input logic [RAND_W-1:0] ra, input logic [RAND_W-1:0] rp,
         input logic [RAND_W-1:0] rn, output triplet_type res);
      longint n, anchor, start, csize, pos, neg;
      int cls;
      res = '0;
      if (kind == KIND_LOAD_CLASS) begin
         if (tval < MAX_CLASSES) begin
            class_of_img[tidx] = tval[CLS_W-1:0];
            img_loaded[tidx] = 1;
         end
         return 0;
      end
      if (kind == KIND_LOAD_START) begin
         if (tidx <= MAX_CLASSES) begin
            class_begin[tidx] = tval;
            begin_loaded[tidx] = 1;
         end
         return 0;
      end
      if (kind != KIND_SAMPLE) return 0;
      n = img_total;
      if (n < 1) n = 1;
      if (n > MAX_IMAGES) n = MAX_IMAGES;
      anchor = longint'(ra) % n;
      cls = class_of_img[anchor];
      start = class_begin[cls];
      csize = longint'(class_begin[cls+1]) - start;
      pos = 0;
      neg = 0;
      res.err = ERR_NONE;
      if (csize - 1 <= 0) res.err = ERR_SMALL;
      else begin
         pos = longint'(rp) % (csize - 1) + start;
         if (pos >= anchor) pos++;
         if (n - csize <= 0) res.err = ERR_NO_OTHER;
         else begin
            neg = longint'(rn) % (n - csize);
            if (neg >= start) neg += csize;
         end
      end
      res.anchor = anchor[15:0];
      res.positive = pos[15:0];
      res.negative = neg[15:0];
      return 1;
   endfunction

   function automatic bit anchor_ok(int a);
      int cls;
      if (!img_loaded[a]) return 0;
      cls = class_of_img[a];
      return begin_loaded[cls] && begin_loaded[cls+1];
   endfunction

   // request monitor: predictor runs in acceptance order
   always @(posedge clock) begin
      triplet_type r;
      if (!reset && req_valid && !req_stall) begin
         if (sample_triplet(req_kind, req_table_index, req_table_value,
               req_rand_anchor, req_rand_positive, req_rand_negative, r))
            triplet_q.insert(triplet_q.size(), cur_typed ? cur_want : r);
      end
   end

   // result checker
   always @(posedge clock) begin
      triplet_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (triplet_q.size() == 0)
            report("result transfer with nothing expected");
         else begin
            w = triplet_q.pop_front();
            if (rsp_anchor_index !== w.anchor)
               report($sformatf("anchor %0d, want %0d", rsp_anchor_index, w.anchor));
            if (rsp_positive_index !== w.positive)
               report($sformatf("positive %0d, want %0d", rsp_positive_index,
                                w.positive));
            if (rsp_negative_index !== w.negative)
               report($sformatf("negative %0d, want %0d", rsp_negative_index,
                                w.negative));
            if (rsp_sample_error !== w.err)
               report($sformatf("error %0d, want %0d", rsp_sample_error, w.err));
         end
      end
   end

   // receiver stall pattern, with a long hold-off on request
   always @(posedge clock) begin
      if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_stall <= hold_off;
         1: rsp_stall <= hold_off || ($urandom_range(0, 3) == 0);
         2: rsp_stall <= hold_off || ($urandom_range(0, 3) != 0);
         default: rsp_stall <= hold_off || !rsp_stall;
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   int burst_left = 0;

   task automatic send(stim_row_type s);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
      burst_left--;
      req_valid         <= 1;
      req_kind          <= s.kind;
      req_table_index   <= s.tidx;
      req_table_value   <= s.tval;
      req_rand_anchor   <= s.ra;
      req_rand_positive <= s.rp;
      req_rand_negative <= s.rn;
      cur_typed         <= s.typed;
      cur_want          <= s.want;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic go_quiet();
      req_valid <= 0;
      burst_left = 0;
      @(posedge clock);
      while (triplet_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_image_total(logic [CNT_W-1:0] v);
      go_quiet();
      repeat (DRAIN_CYCLES) @(posedge clock);
      psel    <= 1;
      pwrite  <= 1;
      penable <= 0;
      paddr   <= ADDR_IMAGE_COUNT;
      pwdata  <= 32'(v);
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel    <= 0;
      penable <= 0;
      pwrite  <= 0;
      img_total = v;
   endtask

   function automatic stim_row_type load_row(logic [KIND_W-1:0] k, int idx, int val);
      stim_row_type s = '0;
      s.kind = k;
      s.tidx = idx[IDX_W-1:0];
      s.tval = val[VAL_W-1:0];
      s.ra = $urandom;
      s.rp = $urandom;
      s.rn = $urandom;
      return s;
   endfunction

   // consistent class-grouped layout at the start of the image list
   task automatic build_layout();
      int p, sz;
      num_classes = $urandom_range(3, 10);
      p = 0;
      for (int c = 0; c < num_classes; c++) begin
         send(load_row(KIND_LOAD_START, c, p));
         sz = (c == 0) ? $urandom_range(2, 12) : $urandom_range(1, 12);
         for (int i = 0; i < sz; i++) send(load_row(KIND_LOAD_CLASS, p + i, c));
         p += sz;
      end
      send(load_row(KIND_LOAD_START, num_classes, p));
      layout_len = p;
   endtask

   function automatic stim_row_type random_row();
      stim_row_type s;
      longint n, a, kmax;
      int pick = $urandom_range(0, 99);
      int lim;
      // class values are either in the layout or out of range (ignored)
      if (pick < 12)
         return load_row(KIND_LOAD_CLASS, $urandom_range(0, 65535),
                         ($urandom_range(0, 7) == 0) ? $urandom_range(MAX_CLASSES, 131071)
                                                     : $urandom_range(0, num_classes - 1));
      if (pick < 17)
         return load_row(KIND_LOAD_START, $urandom_range(0, 1100), $urandom_range(0, 131071));
      if (pick < 21) begin
         s = load_row(KIND_NOP, $urandom_range(0, 65535), $urandom_range(0, 131071));
         return s;
      end
      s = load_row(KIND_SAMPLE, $urandom_range(0, 65535), $urandom_range(0, 131071));
      n = img_total;
      if (n < 1) n = 1;
      if (n > MAX_IMAGES) n = MAX_IMAGES;
      a = longint'(s.ra) % n;
      if (!anchor_ok(int'(a))) begin
         lim = (n < layout_len) ? int'(n) : layout_len;
         a = 0;
         for (int t = 0; t < 10; t++) begin
            a = $urandom_range(0, lim - 1);
            if (anchor_ok(int'(a))) break;
            a = 0;
         end
         kmax = (64'hFFFF_FFFF - a) / n;
         s.ra = 32'(a + n * longint'($urandom_range(0, int'(kmax))));
      end
      return s;
   endfunction

   stim_row_type directed[] = '{
      '{KIND_LOAD_CLASS, 16'd0, 17'd0, 32'd0, 32'd0, 32'd0, 1'b0, '0},
      '{KIND_LOAD_CLASS, 16'd1, 17'd0, 32'd0, 32'd0, 32'd0, 1'b0, '0},
      // class value out of range: ignored
      '{KIND_LOAD_CLASS, 16'd0, 17'd1024, 32'd0, 32'd0, 32'd0, 1'b0, '0},
      '{KIND_LOAD_START, 16'd0, 17'd0, 32'd0, 32'd0, 32'd0, 1'b0, '0},
      '{KIND_LOAD_START, 16'd1, 17'd2, 32'd0, 32'd0, 32'd0, 1'b0, '0},
      // start address past the table: ignored
      '{KIND_LOAD_START, 16'd1025, 17'h1FFFF, 32'd0, 32'd0, 32'd0, 1'b0, '0},
      '{KIND_LOAD_START, 16'd1024, 17'd65536, 32'd0, 32'd0, 32'd0, 1'b0, '0},
      '{KIND_NOP, 16'hFFFF, 17'h1FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
      // one image in the list: class 0 covers all of it
      '{KIND_SAMPLE, 16'd0, 17'd0, 32'd0, 32'd0, 32'd0, 1'b1,
        '{16'd0, 16'd1, 16'd0, ERR_NO_OTHER}},
      '{KIND_SAMPLE, 16'hFFFF, 17'h1FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
        1'b1, '{16'd0, 16'd1, 16'd0, ERR_NO_OTHER}},
      '{KIND_LOAD_CLASS, 16'hFFFF, 17'd1023, 32'd0, 32'd0, 32'd0, 1'b0, '0},
      '{KIND_LOAD_CLASS, 16'd2, 17'd1, 32'd0, 32'd0, 32'd0, 1'b0, '0},
      '{KIND_LOAD_START, 16'd2, 17'd3, 32'd0, 32'd0, 32'd0, 1'b0, '0},
      '{KIND_SAMPLE, 16'd0, 17'd0, 32'h8000_0001, 32'h7FFF_FFFF, 32'h1234_5678,
        1'b0, '0}
   };

   initial begin
      logic [CNT_W-1:0] totals[8];
      reset = 1;
      req_valid = 0;
      req_kind = KIND_LOAD_CLASS;
      req_table_index = 0;
      req_table_value = 0;
      req_rand_anchor = 0;
      req_rand_positive = 0;
      req_rand_negative = 0;
      psel = 0;
      penable = 0;
      pwrite = 0;
      paddr = 0;
      pwdata = 0;
      cur_typed = 0;
      cur_want = '0;
      img_total = 1;
      layout_len = 3;
      num_classes = 2;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      foreach (directed[i]) send(directed[i]);

      totals = '{17'd0, 17'd0, 17'd2, 17'd65536, 17'h1FFFF, 17'd0, 17'd0, 17'd3};
      for (int ph = 0; ph < 8; ph++) begin
         go_quiet();
         repeat (DRAIN_CYCLES) @(posedge clock);
         build_layout();
         if (ph == 1 || ph == 6) totals[ph] = CNT_W'(layout_len);
         if (ph == 5) totals[ph] = CNT_W'($urandom_range(1, 131071));
         write_image_total(totals[ph]);
         for (int i = 0; i < 120; i++) begin
            if (ph == 2 && i == 10) hold_off = 1;
            if (ph == 2 && i == 10)
               fork
                  begin
                     repeat (HOLD_CYCLES) @(posedge clock);
                     hold_off = 0;
                  end
               join_none
            if (ph == 4 && i == 60) go_quiet();
            send(random_row());
         end
      end

      go_quiet();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule

>>> files.f
hw/rtl/tis_pkg.sv
hw/rtl/tis_ram.sv
hw/rtl/tis_mod.sv
hw/rtl/triplet_index_sampler.sv
dv/tb.sv
